FILE: design/signed_int_to_decimal_ascii_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal ASCII unit
// Shared property wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SIDEC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SIDEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sidec_pkg.sv
// ----------------------------------------------------------------------------
// sidec_pkg
// Widths, character codes and the queue entry type of the decimal ASCII unit.
// ----------------------------------------------------------------------------
package sidec_pkg;

  localparam int IntWidth    = 32;
  localparam int InTdataW    = 32;
  // floor((IntWidth-1)*log10(2)) + 1 digits cover the largest magnitude
  localparam int NumDigits   = (((IntWidth - 1) * 1233) >> 12) + 1;
  localparam int BitsPerStep = 4;
  localparam int ConvSteps   = (IntWidth + BitsPerStep - 1) / BitsPerStep;
  localparam int PadWidth    = ConvSteps * BitsPerStep;
  localparam int StepCntW    = $clog2(ConvSteps);
  localparam int NdigW       = $clog2(NumDigits + 1);
  localparam int DigIdxW     = $clog2(NumDigits);
  localparam int CharW       = 6;
  localparam int TextLenW    = 4;
  localparam int LenSumW     = (NdigW + 1 > TextLenW) ? NdigW + 1 : TextLenW;
  localparam int OutTdataW   = ((CharW + TextLenW + 7) / 8) * 8;
  localparam int QueueDepth  = 2;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam int QCntW       = $clog2(QueueDepth + 1);

  localparam logic [CharW-1:0] CharZero  = 6'd48;
  localparam logic [CharW-1:0] CharMinus = 6'd45;

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    logic                       neg;
    logic [NdigW-1:0]           ndig;
    bcd_t [NumDigits-1:0]       digits;
  } entry_t;

endpackage

FILE: design/sidec_front.sv
// ----------------------------------------------------------------------------
// sidec_front
// Takes a value, forms sign and magnitude, converts to BCD four bits a cycle.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_unit_defines.svh"

module sidec_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sidec_pkg::InTdataW-1:0] s_axis_tdata,  // [31:0] value
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output sidec_pkg::entry_t             push_entry_o
);

  localparam logic [1:0] FsIdle = 2'd0;
  localparam logic [1:0] FsConv = 2'd1;
  localparam logic [1:0] FsPush = 2'd2;

  logic [1:0]                         state_q, state_d;
  logic [sidec_pkg::StepCntW-1:0]     step_q, step_d;
  logic                               neg_q;
  logic [sidec_pkg::PadWidth-1:0]     sh_q;
  sidec_pkg::bcd_t [sidec_pkg::NumDigits-1:0] bcd_q;

  logic [sidec_pkg::IntWidth-1:0]     raw_w;
  logic [sidec_pkg::IntWidth-1:0]     mag_w;
  logic [sidec_pkg::PadWidth-1:0]     sh_w;
  sidec_pkg::bcd_t [sidec_pkg::NumDigits-1:0] bcd_w;
  logic [sidec_pkg::NdigW-1:0]        ndig_w;
  logic                               digits_ok_w;
  logic                               accept_w;

  assign accept_w = s_axis_tvalid && s_axis_tready;
  assign raw_w    = s_axis_tdata[sidec_pkg::IntWidth-1:0];
  assign mag_w    = raw_w[sidec_pkg::IntWidth-1] ? (~raw_w + 1'b1) : raw_w;

  // double dabble: add 3 to every digit of 5 or more, then shift in one bit
  always_comb begin
    bcd_w = bcd_q;
    sh_w  = sh_q;
    for (int b = 0; b < sidec_pkg::BitsPerStep; b++) begin
      for (int d = 0; d < sidec_pkg::NumDigits; d++) begin
        if (bcd_w[d] >= 4'd5) begin
          bcd_w[d] = bcd_w[d] + 4'd3;
        end
      end
      {bcd_w, sh_w} = {bcd_w, sh_w} << 1;
    end
  end

  // digit count: highest nonzero digit, at least one
  always_comb begin
    ndig_w      = sidec_pkg::NdigW'(1);
    digits_ok_w = 1'b1;
    for (int d = 0; d < sidec_pkg::NumDigits; d++) begin
      if (bcd_q[d] != 4'd0) begin
        ndig_w = sidec_pkg::NdigW'(d + 1);
      end
      if (bcd_q[d] > 4'd9) begin
        digits_ok_w = 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      FsIdle: begin
        if (s_axis_tvalid) begin
          state_d = FsConv;
          step_d  = '0;
        end
      end
      FsConv: begin
        step_d = step_q + 1'b1;
        if (step_q == sidec_pkg::StepCntW'(sidec_pkg::ConvSteps - 1)) begin
          state_d = FsPush;
        end
      end
      FsPush: begin
        if (push_ready_i) begin
          state_d = FsIdle;
        end
      end
      default: begin
        state_d = FsIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      neg_q <= raw_w[sidec_pkg::IntWidth-1];
      sh_q  <= sidec_pkg::PadWidth'(mag_w);
      bcd_q <= '0;
    end else if (state_q == FsConv) begin
      sh_q  <= sh_w;
      bcd_q <= bcd_w;
    end
  end

  assign s_axis_tready       = (state_q == FsIdle);
  assign push_valid_o        = (state_q == FsPush);
  assign push_entry_o.neg    = neg_q;
  assign push_entry_o.ndig   = ndig_w;
  assign push_entry_o.digits = bcd_q;

  `SIDEC_ASSERT_SAME(a_push_bcd_valid, push_valid_o, digits_ok_w, "front: BCD digit above nine")
  `SIDEC_ASSERT_NEXT(a_busy_after_take, accept_w, !s_axis_tready, "front: ready while converting")
  `SIDEC_ASSERT_NEXT(a_push_held, push_valid_o && !push_ready_i, push_valid_o, "front: push dropped")

endmodule

FILE: design/sidec_queue.sv
// ----------------------------------------------------------------------------
// sidec_queue
// Short register queue of converted values between front and back.
// ----------------------------------------------------------------------------
module sidec_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  sidec_pkg::entry_t push_entry_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output sidec_pkg::entry_t pop_entry_o
);

  sidec_pkg::entry_t             mem_q [sidec_pkg::QueueDepth];
  logic [sidec_pkg::QPtrW-1:0]   wr_q, wr_d;
  logic [sidec_pkg::QPtrW-1:0]   rd_q, rd_d;
  logic [sidec_pkg::QCntW-1:0]   cnt_q, cnt_d;
  logic                          push_w;
  logic                          pop_w;

  assign push_ready_o = (cnt_q != sidec_pkg::QCntW'(sidec_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push_w       = push_valid_i && push_ready_o;
  assign pop_w        = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_w) begin
      wr_d = (wr_q == sidec_pkg::QPtrW'(sidec_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_w) begin
      rd_d = (rd_q == sidec_pkg::QPtrW'(sidec_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_w && !pop_w) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_w && !push_w) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_w) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

FILE: design/sidec_back.sv
// ----------------------------------------------------------------------------
// sidec_back
// Walks one converted value and emits its characters, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_unit_defines.svh"

module sidec_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pop_valid_i,
  output logic                            pop_ready_o,
  input  sidec_pkg::entry_t               pop_entry_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sidec_pkg::OutTdataW-1:0] m_axis_tdata,  // [5:0] character, [9:6] text_length
  output logic                            m_axis_tlast   // last_char
);

  logic                                       busy_q, busy_d;
  logic                                       sign_q, sign_d;
  logic [sidec_pkg::DigIdxW-1:0]              idx_q, idx_d;
  sidec_pkg::bcd_t [sidec_pkg::NumDigits-1:0] digits_q;
  logic [sidec_pkg::TextLenW-1:0]             len_q;

  logic                                       m_valid_q, m_valid_d;
  logic [sidec_pkg::CharW-1:0]                char_q;
  logic [sidec_pkg::TextLenW-1:0]             olen_q;
  logic                                       last_q;

  logic                                       adv_w;
  logic                                       cur_last_w;
  logic                                       take_w;
  logic [sidec_pkg::CharW-1:0]                char_w;
  logic [sidec_pkg::NdigW-1:0]                top_w;
  logic [sidec_pkg::LenSumW-1:0]              tot_w;
  logic                                       mid_take_w;
  logic                                       char_ok_w;
  logic                                       minus_out_w;

  assign adv_w       = busy_q && (!m_valid_q || m_axis_tready);
  assign cur_last_w  = !sign_q && (idx_q == '0);
  assign pop_ready_o = !busy_q || (adv_w && cur_last_w);
  assign take_w      = pop_valid_i && pop_ready_o;
  assign char_w      = sign_q ? sidec_pkg::CharMinus
                              : sidec_pkg::CharZero + sidec_pkg::CharW'(digits_q[idx_q]);
  assign top_w       = pop_entry_i.ndig - 1'b1;
  assign tot_w       = sidec_pkg::LenSumW'(pop_entry_i.ndig)
                     + sidec_pkg::LenSumW'(pop_entry_i.neg);

  always_comb begin
    busy_d = busy_q;
    sign_d = sign_q;
    idx_d  = idx_q;
    if (take_w) begin
      busy_d = 1'b1;
      sign_d = pop_entry_i.neg;
      idx_d  = top_w[sidec_pkg::DigIdxW-1:0];
    end else if (adv_w) begin
      if (cur_last_w) begin
        busy_d = 1'b0;
      end else if (sign_q) begin
        sign_d = 1'b0;
      end else begin
        idx_d = idx_q - 1'b1;
      end
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (adv_w) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      sign_q    <= 1'b0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      sign_q    <= sign_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_w) begin
      digits_q <= pop_entry_i.digits;
      len_q    <= tot_w[sidec_pkg::TextLenW-1:0];
    end
    if (adv_w) begin
      char_q <= char_w;
      olen_q <= len_q;
      last_q <= cur_last_w;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {
    {(sidec_pkg::OutTdataW - sidec_pkg::CharW - sidec_pkg::TextLenW){1'b0}}, olen_q, char_q
  };

  assign mid_take_w  = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
  assign char_ok_w   = (char_q == sidec_pkg::CharMinus)
                    || ((char_q >= sidec_pkg::CharZero) && (char_q <= sidec_pkg::CharZero + 6'd9));
  assign minus_out_w = m_valid_q && (char_q == sidec_pkg::CharMinus);

  `SIDEC_ASSERT_NEXT(a_text_unbroken, mid_take_w, m_axis_tvalid, "back: gap inside a text")
  `SIDEC_ASSERT_SAME(a_char_range, m_valid_q, char_ok_w, "back: character out of range")
  `SIDEC_ASSERT_SAME(a_minus_not_last, minus_out_w, !last_q, "back: minus sign marked last")

endmodule

FILE: design/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts signed 32-bit integers to decimal ASCII text, one char per beat.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one two's complement value per request. The
//   master channel returns its text most significant character first: an
//   optional '-', then the digits without leading zeros ("0" for zero).
//   Every beat carries the character and the total text length; tlast marks
//   the final character.
// Timing:
//   The front converts a value to BCD four magnitude bits a cycle and takes
//   no new request until it has pushed the finished value. A two-entry queue
//   decouples it from the back, which sends one character per cycle while the
//   receiver is ready. A text holds at most 11 characters.
// Reset and stall:
//   Reset empties the queue and the output register. When the receiver
//   stalls, the back holds its output and the front keeps converting until
//   the queue fills, then holds its finished value and keeps tready low.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sidec_pkg::InTdataW-1:0]  s_axis_tdata,  // [31:0] value
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sidec_pkg::OutTdataW-1:0] m_axis_tdata,  // [5:0] character, [9:6] text_length
  output logic                            m_axis_tlast   // last_char
);

  logic              push_valid;
  logic              push_ready;
  sidec_pkg::entry_t push_entry;
  logic              pop_valid;
  logic              pop_ready;
  sidec_pkg::entry_t pop_entry;

  sidec_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_entry_o  (push_entry)
  );

  sidec_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  sidec_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_entry_i   (pop_entry),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives signed values into the decimal ASCII unit and checks every character
// beat against a typed text or a local predictor. Directed rows cover extremes,
// zero and the digit-count boundaries; random values follow with bursty idling
// on both sides and one long receiver hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ResetCycles   = 6;
  localparam int NumRandom     = 238;
  localparam int CalmItems     = 40;
  localparam int PressureItem  = 60;
  localparam int HoldOffCycles = 400;
  localparam int TailCycles    = 40;
  localparam int CycleLimit    = 400000;
  localparam int CharW         = sidec_pkg::CharW;
  localparam int TextLenW      = sidec_pkg::TextLenW;

  typedef struct {
    logic [CharW-1:0]    ch;
    logic [TextLenW-1:0] len;
    logic                last;
  } char_beat_t;

  typedef struct {
    logic [31:0] value;
    string       text;  // empty: use the predictor
  } dir_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [sidec_pkg::InTdataW-1:0]  s_axis_tdata = '0;  // [31:0] value
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [sidec_pkg::OutTdataW-1:0] m_axis_tdata;  // [5:0] character, [9:6] text_length
  logic                            m_axis_tlast;  // last_char

  char_beat_t expected_chars[$];
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  bit         calm = 1'b0;
  bit         hold_off_req = 1'b0;
  bit         holding = 1'b0;
  dir_row_t   dir_rows [22];

  signed_int_to_decimal_ascii_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Expected text of a two's complement value: sign, then digits without
  // leading zeros; the magnitude of the most negative value fits unsigned.
  function automatic void predict_decimal_text(input logic [31:0] value);
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  digs [0:15];
    int          nd;
    int          total;
    char_beat_t  b;
    neg = value[31];
    mag = neg ? (~value + 32'd1) : value;
    nd = 0;
    do begin
      digs[nd] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      nd++;
    end while (mag != 32'd0);
    total = nd + (neg ? 1 : 0);
    if (neg) begin
      b.ch   = sidec_pkg::CharMinus;
      b.len  = TextLenW'(total);
      b.last = 1'b0;
      expected_chars.push_back(b);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      b.ch   = sidec_pkg::CharZero + CharW'(digs[i]);
      b.len  = TextLenW'(total);
      b.last = (i == 0);
      expected_chars.push_back(b);
    end
  endfunction

  function automatic void push_typed_text(input string text);
    char_beat_t b;
    for (int i = 0; i < text.len(); i++) begin
      b.ch   = CharW'(text[i]);
      b.len  = TextLenW'(text.len());
      b.last = (i == text.len() - 1);
      expected_chars.push_back(b);
    end
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    logic [31:0] pow;
    int          w;
    int          sel;
    sel = $urandom_range(0, 19);
    if (sel < 11) begin
      // random magnitude width spreads the text lengths
      w = $urandom_range(1, 32);
      v = $urandom;
      if (w < 32) v = v & ((32'd1 << w) - 32'd1);
    end else if (sel < 15) begin
      pow = 32'd1;
      repeat ($urandom_range(0, 9)) pow = pow * 32'd10;
      v = pow - 32'($urandom_range(0, 1));
    end else if (sel < 17) begin
      case ($urandom_range(0, 3))
        0:       v = 32'h0000_0000;
        1:       v = 32'h7FFF_FFFF;
        2:       v = 32'h8000_0000;
        default: v = 32'hFFFF_FFFF;
      endcase
    end else begin
      v = $urandom;
    end
    if (sel < 15 && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Offer one request and hold it until accepted; then maybe idle.
  task automatic offer_value(input logic [31:0] value, input string text);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (text.len() == 0) predict_decimal_text(value);
    else push_typed_text(text);
    gap = 0;
    if (!calm && !holding && !hold_off_req && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    dir_rows = '{
      '{32'h0000_0000, "0"},
      '{32'h0000_0001, "1"},
      '{32'hFFFF_FFFF, "-1"},
      '{32'h7FFF_FFFF, "2147483647"},
      '{32'h8000_0000, "-2147483648"},
      '{32'h8000_0001, "-2147483647"},
      '{32'd9, ""},
      '{32'd10, ""},
      '{-32'sd9, ""},
      '{-32'sd10, ""},
      '{32'd99, ""},
      '{32'd100, ""},
      '{32'd999999999, ""},
      '{32'd1000000000, ""},
      '{-32'sd999999999, ""},
      '{-32'sd1000000000, ""},
      '{32'h5555_5555, ""},
      '{32'hAAAA_AAAA, ""},
      '{32'h0000_FFFF, ""},
      '{32'hFFFF_0000, ""},
      '{32'd1234567890, ""},
      '{-32'sd123, ""}
    };
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[i]) offer_value(dir_rows[i].value, dir_rows[i].text);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == PressureItem) hold_off_req = 1'b1;
      if (n == NumRandom - CalmItems) calm = 1'b1;
      offer_value(pick_value(), "");
    end
    s_axis_tvalid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** signed_int_to_decimal_ascii_unit: PASSED **");
    end else begin
      $display("** signed_int_to_decimal_ascii_unit: FAILED **");
    end
    $finish;
  end

  // Receiver: short random stalls, one long hold-off on request, none when calm.
  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        holding = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        holding = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_beat
    char_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character beat: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        mismatch_cnt++;
      end else begin
        want = expected_chars.pop_front();
        if (m_axis_tdata[CharW-1:0] !== want.ch) begin
          $error("character: expected %0d, actual %0d", want.ch, m_axis_tdata[CharW-1:0]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[CharW+TextLenW-1:CharW] !== want.len) begin
          $error("text_length: expected %0d, actual %0d", want.len,
                 m_axis_tdata[CharW+TextLenW-1:CharW]);
          mismatch_cnt++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_char: expected %0b, actual %0b", want.last, m_axis_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("** signed_int_to_decimal_ascii_unit: FAILED **");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+design
design/sidec_pkg.sv
design/sidec_front.sv
design/sidec_queue.sv
design/sidec_back.sv
design/signed_int_to_decimal_ascii_unit.sv
tb/testbench.sv
